>>> design/mfrr_pkg.sv
package mfrr_pkg;

	// frame geometry
	localparam int MASK_BLOCKS = 4;
	localparam int FRAME_BYTES = 256;
	localparam int MASK_BYTES  = MASK_BLOCKS * 8;
	localparam int MASK_BITS   = MASK_BYTES * 8;
	localparam int COL_LIMIT   = (FRAME_BYTES < MASK_BITS) ? FRAME_BYTES : MASK_BITS;
	localparam int GRP_W       = $clog2(MASK_BYTES);
	localparam int IDX_W       = GRP_W + 3;

	// mask bits that may carry a column
	localparam logic [MASK_BITS-1:0] LIM_MASK = {MASK_BITS{1'b1}} >> (MASK_BITS - COL_LIMIT);

	// config port
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_DELTA = 2'd0;
	localparam logic [1:0] REG_KEY   = 2'd1;
	localparam logic [1:0] REG_EVENT = 2'd2;

	// section codes
	localparam logic [2:0] SEC_TYPE    = 3'd0;
	localparam logic [2:0] SEC_FLAGS   = 3'd1;
	localparam logic [2:0] SEC_DATA    = 3'd2;
	localparam logic [2:0] SEC_EVENT   = 3'd3;
	localparam logic [2:0] SEC_DISCARD = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TRUNC   = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_MASK,
		PH_DATA,
		PH_EVENT,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0] delta_code;
		logic [7:0] keyframe_code;
		logic [7:0] event_code;
	} codes_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] section;
		logic [8:0] slot;
		logic [1:0] status;
		logic       done_res;
	} res_t;

endpackage

>>> design/mfrr_if.sv
interface mfrr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_body;

	modport source (output valid, output byte_in, output end_of_body, input ready);
	modport sink (input valid, input byte_in, input end_of_body, output ready);
endinterface

interface mfrr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_out;
	logic [2:0] section;
	logic [8:0] slot;
	logic [1:0] status;
	logic       done_res;

	modport source (output valid, output byte_out, output section, output slot,
		output status, output done_res, input ready);
	modport sink (input valid, input byte_out, input section, input slot,
		input status, input done_res, output ready);
endinterface

>>> design/mfrr_cfg.sv
module mfrr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfrr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output mfrr_pkg::codes_t             codes
);
	import mfrr_pkg::*;

	codes_t     codes_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign codes   = codes_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.delta_code    <= 8'd0;
			codes_q.keyframe_code <= 8'd1;
			codes_q.event_code    <= 8'd2;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DELTA: codes_q.delta_code    <= pwdata[7:0];
				REG_KEY:   codes_q.keyframe_code <= pwdata[7:0];
				REG_EVENT: codes_q.event_code    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_DELTA: prdata = {24'd0, codes_q.delta_code};
			REG_KEY:   prdata = {24'd0, codes_q.keyframe_code};
			REG_EVENT: prdata = {24'd0, codes_q.event_code};
			default:   prdata = 32'd0;
		endcase
	end
endmodule

>>> design/mfrr_ffs.sv
module mfrr_ffs (
	input  logic [mfrr_pkg::MASK_BITS-1:0] bits,
	output logic                           found,
	output logic [mfrr_pkg::IDX_W-1:0]     idx
);
	import mfrr_pkg::*;

	logic [MASK_BYTES-1:0] grp_any;
	logic [GRP_W-1:0]      grp_sel;
	logic [7:0]            grp_byte;
	logic [2:0]            bit_sel;

	// first byte with any pending bit
	always_comb begin
		found   = 1'b0;
		grp_sel = '0;
		for (int g = 0; g < MASK_BYTES; g++) begin
			grp_any[g] = |bits[g*8 +: 8];
		end
		for (int g = MASK_BYTES - 1; g >= 0; g--) begin
			if (grp_any[g]) begin
				found   = 1'b1;
				grp_sel = GRP_W'(g);
			end
		end
	end

	// first bit inside that byte
	always_comb begin
		grp_byte = bits[{grp_sel, 3'b000} +: 8];
		bit_sel  = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (grp_byte[j]) bit_sel = 3'(j);
		end
	end

	assign idx = {grp_sel, bit_sel};
endmodule

>>> design/mfrr_route.sv
module mfrr_route (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       byte_in,
	input  logic             end_of_body,
	input  mfrr_pkg::codes_t codes,
	output mfrr_pkg::res_t   res
);
	import mfrr_pkg::*;

	phase_t           phase_q, phase_n;
	logic [GRP_W-1:0] mask_cnt_q, mask_cnt_n;
	logic [IDX_W-1:0] col_q, col_n;
	logic [MASK_BITS-1:0] pend_q, pend_n;
	logic             found;
	logic [IDX_W-1:0] found_idx;

	// pending mask bits: load on mask beats, drop a column once it is routed
	always_comb begin
		pend_n = pend_q;
		if (phase_q == PH_MASK) begin
			for (int g = 0; g < MASK_BYTES; g++) begin
				if (mask_cnt_q == GRP_W'(g)) pend_n[g*8 +: 8] = byte_in & LIM_MASK[g*8 +: 8];
			end
		end else if (phase_q == PH_DATA) begin
			pend_n[col_q] = 1'b0;
		end
	end

	mfrr_ffs u_ffs (
		.bits  (pend_n),
		.found (found),
		.idx   (found_idx)
	);

	// classification and next state
	always_comb begin
		phase_n       = phase_q;
		mask_cnt_n    = mask_cnt_q;
		col_n         = col_q;
		res.byte_out  = byte_in;
		res.section   = SEC_DISCARD;
		res.slot      = 9'd0;
		res.done_res  = end_of_body;
		unique case (phase_q)
			PH_TYPE: begin
				if (byte_in == codes.delta_code || byte_in == codes.keyframe_code) begin
					res.section = SEC_TYPE;
					phase_n     = PH_MASK;
					mask_cnt_n  = '0;
					col_n       = '0;
				end else if (byte_in == codes.event_code) begin
					res.section = SEC_TYPE;
					phase_n     = PH_EVENT;
				end else begin
					phase_n = PH_ERR;
				end
			end
			PH_MASK: begin
				res.section = SEC_FLAGS;
				res.slot    = 9'(mask_cnt_q >> 3);
				if (mask_cnt_q == GRP_W'(MASK_BYTES - 1)) begin
					mask_cnt_n = '0;
					if (found) begin
						col_n   = found_idx;
						phase_n = PH_DATA;
					end else begin
						phase_n = PH_TYPE;
					end
				end else begin
					mask_cnt_n = mask_cnt_q + 1'b1;
				end
			end
			PH_DATA: begin
				res.section = SEC_DATA;
				res.slot    = 9'(col_q);
				if (found) col_n = found_idx;
				else phase_n = PH_TYPE;
			end
			PH_EVENT: begin
				res.section = SEC_EVENT;
				phase_n     = PH_TYPE;
			end
			PH_ERR: begin
				phase_n = PH_ERR;
			end
			default: begin
				phase_n = PH_ERR;
			end
		endcase

		// status, and body restart on the final byte
		if (phase_n == PH_ERR) res.status = ST_CORRUPT;
		else if (end_of_body && phase_n != PH_TYPE) res.status = ST_TRUNC;
		else res.status = ST_OK;
		if (end_of_body) begin
			phase_n    = PH_TYPE;
			mask_cnt_n = '0;
			col_n      = '0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			mask_cnt_q <= '0;
			col_q      <= '0;
		end else if (fire) begin
			phase_q    <= phase_n;
			mask_cnt_q <= mask_cnt_n;
			col_q      <= col_n;
		end
	end

	// mask store
	always_ff @(posedge clk) begin
		if (fire) pend_q <= pend_n;
	end
endmodule

>>> design/masked_frame_row_to_column_router_unit.sv
// Masked frame row to column router.
// in_ch carries the record body one byte per beat (byte_in, end_of_body set
// on the final byte); out_ch returns one beat per input beat, in order, with
// the byte, its section, its slot (mask block or column), a status and
// done_res. The APB port holds the delta, keyframe and event type codes at
// byte addresses 0, 4 and 8; write it only while no beat is in flight.
// Each beat passes through the input register, then the result register.
// Throughput: one beat per cycle while out_ch does not stall, set by the
// combinational priority encoder that picks the next set mask bit and
// loads the column register.
// Reset clears the phase, counters and valids and restores the default type
// codes; mask contents are not cleared and are always rewritten before use.
// When out_ch stalls, the result register holds and the input register
// still takes one more beat; after that in_ch.ready drops until out_ch
// drains. The body state restarts itself after each final byte.
module masked_frame_row_to_column_router_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	mfrr_in_if.sink                      in_ch,
	mfrr_out_if.source                   out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mfrr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import mfrr_pkg::*;

	codes_t     codes;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;
	logic       valid_s2;
	res_t       res;
	res_t       res_s2;
	logic       adv;

	mfrr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.codes   (codes)
	);

	// handshake between stages
	assign adv         = valid_s1 & (~valid_s2 | out_ch.ready);
	assign in_ch.ready = ~valid_s1 | adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.byte_in;
			eob_s1  <= in_ch.end_of_body;
		end
	end

	mfrr_route u_route (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.byte_in     (byte_s1),
		.end_of_body (eob_s1),
		.codes       (codes),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.byte_out = res_s2.byte_out;
	assign out_ch.section  = res_s2.section;
	assign out_ch.slot     = res_s2.slot;
	assign out_ch.status   = res_s2.status;
	assign out_ch.done_res = res_s2.done_res;
endmodule

>>> design/mfrr_chk.sv
module mfrr_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] byte_out,
	input logic [2:0] section,
	input logic [8:0] slot,
	input logic [1:0] status,
	input logic       done_res
);
	import mfrr_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_out) && $stable(section)
			&& $stable(slot) && $stable(status) && $stable(done_res))
		else $error("stalled result beat changed");

	// corrupt status only on discarded bytes
	a_corrupt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CORRUPT |-> section == SEC_DISCARD)
		else $error("corrupt status on a routed byte");

	// slot is zero outside mask flags and column data
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section != SEC_FLAGS && section != SEC_DATA |-> slot == 9'd0)
		else $error("nonzero slot outside flags and data");

	// truncation is reported only on the final byte
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TRUNC |-> done_res)
		else $error("truncated status before end of body");
endmodule

bind masked_frame_row_to_column_router_unit mfrr_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.byte_out  (out_ch.byte_out),
	.section   (out_ch.section),
	.slot      (out_ch.slot),
	.status    (out_ch.status),
	.done_res  (out_ch.done_res)
);

>>> tb/tb_masked_frame_row_to_column_router_unit.sv
module tb_masked_frame_row_to_column_router_unit;
	import mfrr_pkg::*;

	// mask fill patterns for generated frames
	localparam int MASK_ZERO   = 0;
	localparam int MASK_FULL   = 1;
	localparam int MASK_DENSE  = 2;
	localparam int MASK_SPARSE = 3;
	localparam int MASK_ENDS   = 4;

	localparam int RANDOM_BYTES = 700;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	mfrr_in_if  in_ch ();
	mfrr_out_if out_ch ();

	masked_frame_row_to_column_router_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// router model state
	codes_t       codes = {8'd0, 8'd1, 8'd2};
	phase_t       ph = PH_TYPE;
	logic [7:0]   mask_mem [MASK_BYTES];
	int unsigned  mask_idx = 0;
	int unsigned  col = 0;
	logic [1:0]   err = ST_OK;

	res_t         expected_routes [$];
	logic [7:0]   body_q [$];

	// run bookkeeping
	int unsigned  bytes_sent = 0;
	int unsigned  beats_checked = 0;
	int unsigned  bodies_seen = 0;
	int unsigned  frames_seen = 0;
	int unsigned  events_seen = 0;
	int unsigned  corrupt_seen = 0;
	int unsigned  code_settings = 0;
	int unsigned  mismatches = 0;

	// idling controls
	bit           tx_idle_on = 1'b0;
	bit           rx_idle_on = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  rx_wait = 0;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 20)
			$display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// append one byte to the body under construction
	task automatic append_byte(input logic [7:0] b);
		body_q = {body_q, b};
	endtask

	// first set mask bit at or above from that can carry a column
	function automatic int unsigned first_column(input int unsigned from);
		for (int unsigned i = from; i < COL_LIMIT; i++)
			if (mask_mem[i >> 3][i & 7])
				return i;
		return COL_LIMIT;
	endfunction

	// classify one body byte and advance the frame state
	function automatic res_t route_byte(input logic [7:0] b, input logic last);
		res_t r;
		r.byte_out = b;
		r.section  = SEC_DISCARD;
		r.slot     = '0;
		r.done_res = last;
		case (ph)
			PH_TYPE: begin
				if (b == codes.delta_code || b == codes.keyframe_code) begin
					r.section = SEC_TYPE;
					ph = PH_MASK;
					mask_idx = 0;
					col = 0;
					frames_seen++;
				end else if (b == codes.event_code) begin
					r.section = SEC_TYPE;
					ph = PH_EVENT;
					events_seen++;
				end else begin
					err = ST_CORRUPT;
					ph = PH_ERR;
					corrupt_seen++;
				end
			end
			PH_MASK: begin
				r.section = SEC_FLAGS;
				r.slot = 9'(mask_idx >> 3);
				mask_mem[mask_idx] = b;
				mask_idx++;
				if (mask_idx >= MASK_BYTES) begin
					mask_idx = 0;
					col = first_column(0);
					ph = (col < COL_LIMIT) ? PH_DATA : PH_TYPE;
				end
			end
			PH_DATA: begin
				r.section = SEC_DATA;
				r.slot = 9'(col);
				col = first_column(col + 1);
				if (col >= COL_LIMIT)
					ph = PH_TYPE;
			end
			PH_EVENT: begin
				r.section = SEC_EVENT;
				ph = PH_TYPE;
			end
			default: begin
				ph = PH_ERR;
			end
		endcase
		r.status = err;
		// final byte closes the body, flagging an open frame
		if (last) begin
			if (err == ST_OK && ph != PH_TYPE)
				r.status = ST_TRUNC;
			ph = PH_TYPE;
			mask_idx = 0;
			col = 0;
			err = ST_OK;
			bodies_seen++;
		end
		return r;
	endfunction

	// result beat checker
	always @(posedge clk) begin
		res_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_routes.size() == 0) begin
				report_mismatch("unexpected beat, byte", int'(out_ch.byte_out), -1);
			end else begin
				want = expected_routes.pop_front();
				beats_checked++;
				if (out_ch.byte_out !== want.byte_out)
					report_mismatch("byte_out", int'(out_ch.byte_out),
						int'(want.byte_out));
				if (out_ch.section !== want.section)
					report_mismatch("section", int'(out_ch.section), int'(want.section));
				if (out_ch.slot !== want.slot)
					report_mismatch("slot", int'(out_ch.slot), int'(want.slot));
				if (out_ch.status !== want.status)
					report_mismatch("status", int'(out_ch.status), int'(want.status));
				if (out_ch.done_res !== want.done_res)
					report_mismatch("done_res", int'(out_ch.done_res),
						int'(want.done_res));
			end
		end
	end

	// result ready: long hold-off first, then random stalls when rx_idle_on is set
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else if (rx_wait > 0) begin
			out_ch.ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ch.ready <= 1'b1;
			if (rx_idle_on)
				rx_wait = pick_gap();
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= b;
		in_ch.end_of_body <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		expected_routes = {expected_routes, route_byte(b, last)};
		bytes_sent++;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// send body_q[first..last_idx], end_of_body on the body's final byte
	task automatic send_span(input int unsigned first, input int unsigned last_idx);
		for (int unsigned i = first; i <= last_idx; i++)
			send_byte(body_q[i], i == body_q.size() - 1);
	endtask

	task automatic send_body();
		send_span(0, body_q.size() - 1);
	endtask

	// drop valid and wait until every expected beat has come back
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (expected_routes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_code(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_DELTA: codes.delta_code = val;
			REG_KEY:   codes.keyframe_code = val;
			REG_EVENT: codes.event_code = val;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_code(input logic [1:0] idx, input logic [7:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[7:0] !== want)
			report_mismatch("register readback", int'(prdata[7:0]), int'(want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// reprogram all three type codes on an idle block
	task automatic set_codes(input logic [7:0] d, input logic [7:0] k, input logic [7:0] e);
		wait_drained();
		write_code(REG_DELTA, d);
		write_code(REG_KEY, k);
		write_code(REG_EVENT, e);
		read_code(REG_DELTA, d);
		read_code(REG_KEY, k);
		read_code(REG_EVENT, e);
		code_settings++;
	endtask

	// type byte, mask bytes, then one data byte per usable set bit
	task automatic push_frame(input logic [7:0] code, input int pattern);
		logic [7:0]  m [MASK_BYTES];
		int unsigned cols;
		cols = 0;
		append_byte(code);
		for (int i = 0; i < MASK_BYTES; i++) begin
			case (pattern)
				MASK_FULL:   m[i] = 8'hFF;
				MASK_DENSE:  m[i] = 8'($urandom);
				MASK_SPARSE: m[i] = ($urandom_range(0, 5) == 0) ?
					8'(8'h01 << $urandom_range(0, 7)) : 8'h00;
				default:     m[i] = 8'h00;
			endcase
		end
		if (pattern == MASK_ENDS) begin
			m[0][0] = 1'b1;
			m[(COL_LIMIT - 1) >> 3][(COL_LIMIT - 1) & 7] = 1'b1;
		end
		for (int i = 0; i < MASK_BYTES; i++) begin
			append_byte(m[i]);
			for (int j = 0; j < 8; j++)
				if (m[i][j] && (i * 8 + j) < COL_LIMIT)
					cols++;
		end
		repeat (cols) append_byte(8'($urandom));
	endtask

	// random body: mostly well-formed records, some noise, sometimes cut short
	task automatic fill_body(input int unsigned records);
		int unsigned kind;
		int unsigned r;
		int          pattern;
		logic [7:0]  b;
		body_q.delete();
		repeat (records) begin
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				r = $urandom_range(0, 39);
				if (r < 3)
					pattern = MASK_ZERO;
				else if (r < 4)
					pattern = MASK_FULL;
				else if (r < 7)
					pattern = MASK_DENSE;
				else
					pattern = MASK_SPARSE;
				push_frame((kind < 7) ? codes.delta_code : codes.keyframe_code, pattern);
			end else if (kind < 18) begin
				append_byte(codes.event_code);
				append_byte(8'($urandom));
			end else if (kind == 18) begin
				// unknown type byte
				b = 8'($urandom);
				while (b == codes.delta_code || b == codes.keyframe_code ||
						b == codes.event_code)
					b = 8'($urandom);
				append_byte(b);
				repeat ($urandom_range(0, 4)) append_byte(8'($urandom));
			end else begin
				append_byte(8'($urandom));
			end
		end
		if ($urandom_range(0, 3) == 0)
			body_q = body_q[0:$urandom_range(0, body_q.size() - 1)];
	endtask

	task automatic test_register_access();
		read_code(REG_DELTA, 8'd0);
		read_code(REG_KEY, 8'd1);
		read_code(REG_EVENT, 8'd2);
		set_codes(8'hFF, 8'h00, 8'hFF);
		set_codes(8'd0, 8'd1, 8'd2);
	endtask

	task automatic test_directed_cases();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// event, empty-mask keyframe, delta with first and last columns
		body_q.delete();
		append_byte(codes.event_code);
		append_byte(8'hA5);
		push_frame(codes.keyframe_code, MASK_ZERO);
		push_frame(codes.delta_code, MASK_ENDS);
		body_q[body_q.size() - 2] = 8'h00;
		body_q[body_q.size() - 1] = 8'hFF;
		append_byte(codes.event_code);
		append_byte(8'hFF);
		send_body();
		// unknown type latches corrupt, rest discarded
		body_q.delete();
		append_byte(8'h33);
		append_byte(8'h00);
		append_byte(8'hFF);
		send_body();
		// body ends right after an event type byte
		body_q.delete();
		append_byte(codes.event_code);
		send_body();
		// body ends inside the mask bytes
		body_q.delete();
		append_byte(codes.keyframe_code);
		repeat (3) append_byte(8'h5A);
		send_body();
		// body ends on a data byte before the frame completes
		body_q.delete();
		push_frame(codes.delta_code, MASK_FULL);
		body_q = body_q[0:MASK_BYTES + 2];
		send_body();
		wait_drained();
	endtask

	task automatic test_output_hold();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		// long enough body to fill both stages during the hold-off
		do
			fill_body(3);
		while (body_q.size() < 8);
		hold_left = 80;
		send_body();
		wait_drained();
	endtask

	task automatic test_drain_pause();
		int unsigned half;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		fill_body(4);
		half = body_q.size() / 2;
		if (half > 0) begin
			send_span(0, half - 1);
			wait_drained();
		end
		send_span(half, body_q.size() - 1);
		wait_drained();
	endtask

	task automatic test_random_bodies();
		int unsigned stop_at;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_codes(8'h00, 8'hFF, 8'h80);
				1: set_codes(8'($urandom), 8'($urandom), 8'($urandom));
				2: set_codes(8'hFF, 8'hFF, 8'hFF);
				3: set_codes(8'h5A, 8'hC3, 8'h5A);
				default: set_codes(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			tx_idle_on = (p != 1);
			rx_idle_on = (p != 1) && (p != 3);
			stop_at = bytes_sent + RANDOM_BYTES / 5;
			while (bytes_sent < stop_at) begin
				fill_body($urandom_range(1, 4));
				send_body();
			end
		end
		wait_drained();
	endtask

	// run limit
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.byte_in = '0;
		in_ch.end_of_body = 1'b0;
		out_ch.ready = 1'b0;
		foreach (mask_mem[i])
			mask_mem[i] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_register_access();
		test_directed_cases();
		test_output_hold();
		test_drain_pause();
		test_random_bodies();

		wait_drained();
		repeat (8) @(posedge clk);
		if (expected_routes.size() != 0)
			report_mismatch("beats still owed", 0, expected_routes.size());
		$display("tb: %0d bytes checked over %0d bodies (%0d frames, %0d events, %0d corrupt)",
			beats_checked, bodies_seen, frames_seen, events_seen, corrupt_seen);
		$display("tb: %0d type code settings, %0d mismatches", code_settings, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
